// File: design/flvp_pkg.sv
// Package with the word types, field codes and FourCC constants of the FLV video tag parser.
package flvp_pkg;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic FAULT_SHORT = 1'b0;
    localparam logic FAULT_UNSUP = 1'b1;

    localparam logic [31:0] FCC_HVC1 = 32'h6876_6331;
    localparam logic [31:0] FCC_VP09 = 32'h7670_3039;
    localparam logic [31:0] FCC_AV01 = 32'h6176_3031;

    localparam logic [3:0] CODEC_HEVC = 4'd0;
    localparam logic [3:0] CODEC_VP9  = 4'd1;
    localparam logic [3:0] CODEC_AV1  = 4'd2;
    localparam logic [3:0] LEGACY_AVC = 4'd7;

    localparam logic [3:0] EPT_SEQ_HEADER  = 4'd0;
    localparam logic [3:0] EPT_NALU        = 4'd1;
    localparam logic [3:0] EPT_END_OF_SEQ  = 4'd2;
    localparam logic [3:0] EPT_NALU_NO_OFS = 4'd3;

    localparam int POS_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_tag;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         kind;
        logic               enhanced;
        logic [3:0]         frame_type;
        logic [3:0]         codec_id;
        logic [7:0]         packet_kind;
        logic signed [23:0] time_offset;
        logic [7:0]         payload_byte;
        logic               fault_code;
        logic               final_res;
    } t_out_word;

endpackage

// File: design/flv_video_tag_parser_top.sv
// Top level of the FLV video tag parser with its output register and skid stage.
//
//   Channel   Valid         Stall         Word
//   input     i_in_valid    o_in_stall    i_in_word  (data_byte, end_of_tag)
//   output    o_out_valid   i_out_stall   o_out_word (kind .. final_res)
//
// One byte is accepted in every cycle unless o_in_stall is high; its result,
// if any, is registered in the output register, or else in the skid register.
// Reset clears the parser state and empties the output and skid registers.
// When the output is stalled, one more result goes into the skid register,
// and the input stalls until that register has drained.
module flv_video_tag_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  flvp_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output flvp_pkg::t_out_word o_out_word
);

    logic                r_out_valid;
    flvp_pkg::t_out_word r_out_word;
    logic                r_skid_valid;
    flvp_pkg::t_out_word r_skid_word;

    logic                accept;
    logic                res_valid;
    flvp_pkg::t_out_word res;
    logic                out_free;

    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    flvp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_in_word),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_word <= r_skid_word;
            end else if (res_valid) begin
                r_out_word <= res;
            end
        end else if (res_valid) begin
            r_skid_word <= res;
        end
    end

endmodule

// File: design/flvp_core.sv
// Byte parser of the FLV video tag header with its position counter and shift registers.
module flvp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  flvp_pkg::t_in_word  i_word,
    output logic                o_res_valid,
    output flvp_pkg::t_out_word o_res
);

    localparam logic [flvp_pkg::POS_W-1:0] POS_ONE        = flvp_pkg::POS_W'(1);
    localparam logic [flvp_pkg::POS_W-1:0] POS_LEGACY_END = flvp_pkg::POS_W'(4);
    localparam logic [flvp_pkg::POS_W-1:0] POS_FOURCC_END = flvp_pkg::POS_W'(4);
    localparam logic [flvp_pkg::POS_W-1:0] POS_ENH_END    = flvp_pkg::POS_W'(7);

    logic [flvp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]  r_first, n_first;
    logic [31:0] r_fourcc, n_fourcc;
    logic [23:0] r_offset, n_offset;
    logic [7:0]  r_legacy_pkt, n_legacy_pkt;
    logic        r_header_done, n_header_done;
    logic        r_dropping, n_dropping;

    logic [7:0]  b;
    logic        last;
    logic [31:0] fourcc_sh;
    logic [23:0] offset_sh;
    logic [3:0]  ept;
    logic [3:0]  codec_enh;
    logic        fourcc_ok;
    logic        emit_hdr;
    logic        emit_err;

    assign b         = i_word.data_byte;
    assign last      = i_word.end_of_tag;
    assign fourcc_sh = {r_fourcc[23:0], b};
    assign offset_sh = {r_offset[15:0], b};
    assign ept       = r_first[6:3];

    always_comb begin
        fourcc_ok = 1'b1;
        codec_enh = flvp_pkg::CODEC_AV1;
        priority if (fourcc_sh == flvp_pkg::FCC_HVC1) begin
            codec_enh = flvp_pkg::CODEC_HEVC;
        end else if (fourcc_sh == flvp_pkg::FCC_VP09) begin
            codec_enh = flvp_pkg::CODEC_VP9;
        end else if (fourcc_sh == flvp_pkg::FCC_AV01) begin
            codec_enh = flvp_pkg::CODEC_AV1;
        end else begin
            fourcc_ok = 1'b0;
        end
    end

    always_comb begin
        n_pos         = r_pos;
        n_first       = r_first;
        n_fourcc      = r_fourcc;
        n_offset      = r_offset;
        n_legacy_pkt  = r_legacy_pkt;
        n_header_done = r_header_done;
        n_dropping    = r_dropping;
        o_res         = '0;
        o_res_valid   = 1'b0;
        emit_hdr      = 1'b0;
        emit_err      = 1'b0;

        if (i_accept) begin
            if (r_dropping) begin
                o_res_valid = 1'b0;
            end else if (r_header_done) begin
                o_res_valid        = 1'b1;
                o_res.kind         = flvp_pkg::KIND_PAYLOAD;
                o_res.payload_byte = b;
            end else if (r_pos == '0) begin
                n_first = b;
                if (!b[7] && (b[3:0] != flvp_pkg::LEGACY_AVC)) begin
                    emit_hdr         = 1'b1;
                    o_res.frame_type = b[7:4];
                    o_res.codec_id   = b[3:0];
                end else if (last) begin
                    emit_err         = 1'b1;
                    o_res.fault_code = flvp_pkg::FAULT_SHORT;
                end else begin
                    n_pos = POS_ONE;
                end
            end else if (r_first[7]) begin
                if (r_pos <= POS_FOURCC_END) begin
                    n_fourcc = fourcc_sh;
                    if (r_pos != POS_FOURCC_END) begin
                        if (last) begin
                            emit_err         = 1'b1;
                            o_res.fault_code = flvp_pkg::FAULT_SHORT;
                        end else begin
                            n_pos = r_pos + POS_ONE;
                        end
                    end else if (!fourcc_ok || ept > flvp_pkg::EPT_NALU_NO_OFS) begin
                        emit_err         = 1'b1;
                        o_res.fault_code = flvp_pkg::FAULT_UNSUP;
                    end else if (ept == flvp_pkg::EPT_NALU) begin
                        if (last) begin
                            emit_err         = 1'b1;
                            o_res.fault_code = flvp_pkg::FAULT_SHORT;
                        end else begin
                            n_pos = r_pos + POS_ONE;
                        end
                    end else begin
                        emit_hdr          = 1'b1;
                        o_res.enhanced    = 1'b1;
                        o_res.frame_type  = {1'b0, r_first[2:0]};
                        o_res.codec_id    = codec_enh;
                        o_res.packet_kind = (ept == flvp_pkg::EPT_NALU_NO_OFS) ?
                                            {4'd0, flvp_pkg::EPT_NALU} : {4'd0, ept};
                    end
                end else begin
                    n_offset = offset_sh;
                    if (r_pos != POS_ENH_END) begin
                        if (last) begin
                            emit_err         = 1'b1;
                            o_res.fault_code = flvp_pkg::FAULT_SHORT;
                        end else begin
                            n_pos = r_pos + POS_ONE;
                        end
                    end else begin
                        emit_hdr          = 1'b1;
                        o_res.enhanced    = 1'b1;
                        o_res.frame_type  = {1'b0, r_first[2:0]};
                        o_res.codec_id    = (r_fourcc == flvp_pkg::FCC_HVC1) ?
                                            flvp_pkg::CODEC_HEVC :
                                            ((r_fourcc == flvp_pkg::FCC_VP09) ?
                                             flvp_pkg::CODEC_VP9 : flvp_pkg::CODEC_AV1);
                        o_res.packet_kind = {4'd0, flvp_pkg::EPT_NALU};
                        o_res.time_offset = offset_sh;
                    end
                end
            end else if (r_pos == POS_ONE) begin
                n_legacy_pkt = b;
                if (last) begin
                    emit_err         = 1'b1;
                    o_res.fault_code = flvp_pkg::FAULT_SHORT;
                end else begin
                    n_pos = r_pos + POS_ONE;
                end
            end else begin
                n_offset = offset_sh;
                if (r_pos != POS_LEGACY_END) begin
                    if (last) begin
                        emit_err         = 1'b1;
                        o_res.fault_code = flvp_pkg::FAULT_SHORT;
                    end else begin
                        n_pos = r_pos + POS_ONE;
                    end
                end else begin
                    emit_hdr          = 1'b1;
                    o_res.frame_type  = r_first[7:4];
                    o_res.codec_id    = r_first[3:0];
                    o_res.packet_kind = r_legacy_pkt;
                    o_res.time_offset = offset_sh;
                end
            end

            if (emit_hdr) begin
                o_res_valid   = 1'b1;
                o_res.kind    = flvp_pkg::KIND_HEADER;
                n_header_done = 1'b1;
            end
            if (emit_err) begin
                o_res             = '0;
                o_res_valid       = 1'b1;
                o_res.kind        = flvp_pkg::KIND_ERROR;
                o_res.fault_code  = (ept > flvp_pkg::EPT_NALU_NO_OFS || !fourcc_ok) &&
                                    r_first[7] && (r_pos == POS_FOURCC_END) &&
                                    !r_dropping && !r_header_done;
                n_dropping        = 1'b1;
            end
            o_res.final_res = o_res_valid && last;

            // Every body ends with all parser state back at zero.
            if (last) begin
                n_pos         = '0;
                n_first       = '0;
                n_fourcc      = '0;
                n_offset      = '0;
                n_legacy_pkt  = '0;
                n_header_done = 1'b0;
                n_dropping    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_first       <= '0;
            r_fourcc      <= '0;
            r_offset      <= '0;
            r_legacy_pkt  <= '0;
            r_header_done <= 1'b0;
            r_dropping    <= 1'b0;
        end else begin
            r_pos         <= n_pos;
            r_first       <= n_first;
            r_fourcc      <= n_fourcc;
            r_offset      <= n_offset;
            r_legacy_pkt  <= n_legacy_pkt;
            r_header_done <= n_header_done;
            r_dropping    <= n_dropping;
        end
    end

endmodule

// File: bench/tb.sv
// Self-checking testbench of the FLV video tag parser: directed bodies, then random bodies.
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_RESULT,
        ROW_SILENT
    } t_row_mode;

    typedef struct {
        logic [7:0]          data_byte;
        logic                last;
        t_row_mode           mode;
        flvp_pkg::t_out_word word;
    } t_row;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    flvp_pkg::t_in_word  in_word = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    flvp_pkg::t_out_word out_word;

    flvp_pkg::t_out_word due_results[$];
    t_row      dir_rows[$];
    int        mismatches = 0;
    int        bytes_sent = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    int        cycle_count = 0;
    logic      hold_req = 1'b0;

    logic [3:0]  byte_pos;
    logic [7:0]  lead_byte;
    logic [31:0] fourcc_acc;
    logic [23:0] offset_acc;
    logic [7:0]  avc_pkt;
    logic        in_payload;
    logic        discarding;

    flv_video_tag_parser_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic flvp_pkg::t_out_word header_word(input logic enh, input logic [3:0] ft,
                                              input logic [3:0] codec, input logic [7:0] pkt,
                                              input logic [23:0] offs, input logic last);
        flvp_pkg::t_out_word w;
        w = '0;
        w.kind = flvp_pkg::KIND_HEADER;
        w.enhanced = enh;
        w.frame_type = ft;
        w.codec_id = codec;
        w.packet_kind = pkt;
        w.time_offset = offs;
        w.final_res = last;
        return w;
    endfunction

    function automatic flvp_pkg::t_out_word payload_word(input logic [7:0] b, input logic last);
        flvp_pkg::t_out_word w;
        w = '0;
        w.kind = flvp_pkg::KIND_PAYLOAD;
        w.payload_byte = b;
        w.final_res = last;
        return w;
    endfunction

    function automatic flvp_pkg::t_out_word fault_word(input logic code, input logic last);
        flvp_pkg::t_out_word w;
        w = '0;
        w.kind = flvp_pkg::KIND_ERROR;
        w.fault_code = code;
        w.final_res = last;
        return w;
    endfunction

    function automatic void clear_parser();
        byte_pos = '0;
        lead_byte = '0;
        fourcc_acc = '0;
        offset_acc = '0;
        avc_pkt = '0;
        in_payload = 1'b0;
        discarding = 1'b0;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last, output logic has,
                              output flvp_pkg::t_out_word w);
        logic [3:0] codec;
        logic       codec_ok;
        logic [3:0] ept;
        logic [7:0] pkt;
        has = 1'b0;
        w = '0;
        if (discarding) begin
        end else if (in_payload) begin
            has = 1'b1;
            w = payload_word(b, last);
        end else if (byte_pos == 0) begin
            lead_byte = b;
            if (!b[7] && b[3:0] != flvp_pkg::LEGACY_AVC) begin
                has = 1'b1;
                w = header_word(1'b0, b[7:4], b[3:0], 8'd0, 24'd0, last);
            end else if (last) begin
                has = 1'b1;
                w = fault_word(flvp_pkg::FAULT_SHORT, last);
            end else begin
                byte_pos = 4'd1;
            end
        end else if (lead_byte[7]) begin
            if (byte_pos <= 4)
                fourcc_acc = {fourcc_acc[23:0], b};
            else
                offset_acc = {offset_acc[15:0], b};
            codec_ok = 1'b1;
            codec = flvp_pkg::CODEC_AV1;
            unique case (fourcc_acc)
                flvp_pkg::FCC_HVC1: codec = flvp_pkg::CODEC_HEVC;
                flvp_pkg::FCC_VP09: codec = flvp_pkg::CODEC_VP9;
                flvp_pkg::FCC_AV01: codec = flvp_pkg::CODEC_AV1;
                default:            codec_ok = 1'b0;
            endcase
            ept = lead_byte[6:3];
            pkt = {4'd0, (ept == flvp_pkg::EPT_NALU_NO_OFS) ? flvp_pkg::EPT_NALU : ept};
            if (byte_pos == 4 && (!codec_ok || ept > flvp_pkg::EPT_NALU_NO_OFS)) begin
                has = 1'b1;
                w = fault_word(flvp_pkg::FAULT_UNSUP, last);
            end else if (byte_pos == 7 || (byte_pos == 4 && ept != flvp_pkg::EPT_NALU)) begin
                has = 1'b1;
                w = header_word(1'b1, {1'b0, lead_byte[2:0]}, codec, pkt,
                                (byte_pos == 7) ? offset_acc : 24'd0, last);
            end else if (last) begin
                has = 1'b1;
                w = fault_word(flvp_pkg::FAULT_SHORT, last);
            end else begin
                byte_pos = byte_pos + 4'd1;
            end
        end else begin
            if (byte_pos == 1)
                avc_pkt = b;
            else
                offset_acc = {offset_acc[15:0], b};
            if (byte_pos == 4) begin
                has = 1'b1;
                w = header_word(1'b0, lead_byte[7:4], lead_byte[3:0], avc_pkt, offset_acc, last);
            end else if (last) begin
                has = 1'b1;
                w = fault_word(flvp_pkg::FAULT_SHORT, last);
            end else begin
                byte_pos = byte_pos + 4'd1;
            end
        end
        if (has && !last) begin
            if (w.kind == flvp_pkg::KIND_ERROR)
                discarding = 1'b1;
            else if (w.kind == flvp_pkg::KIND_HEADER)
                in_payload = 1'b1;
        end
        if (last)
            clear_parser();
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input t_row_mode mode,
                             input flvp_pkg::t_out_word typed);
        logic                has;
        flvp_pkg::t_out_word w;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{data_byte: b, end_of_tag: last};
        do
            @(posedge clk);
        while (in_stall);
        parse_byte(b, last, has, w);
        if (mode == ROW_RESULT)
            due_results.push_back(typed);
        else if (mode == ROW_PREDICT && has)
            due_results.push_back(w);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic add_row(input logic [7:0] b, input logic last, input t_row_mode mode,
                           input flvp_pkg::t_out_word w);
        dir_rows.push_back('{data_byte: b, last: last, mode: mode, word: w});
    endtask

    task automatic send_random_body();
        logic [7:0]  body[$];
        logic [7:0]  b0;
        logic [31:0] fcc;
        logic [3:0]  ept;
        int          pick;
        int          n;
        pick = $urandom_range(99);
        case ($urandom_range(2))
            0:       fcc = flvp_pkg::FCC_HVC1;
            1:       fcc = flvp_pkg::FCC_VP09;
            default: fcc = flvp_pkg::FCC_AV01;
        endcase
        ept = 4'($urandom_range(3));
        if (pick < 20) begin
            b0 = 8'($urandom_range(127));
            if (b0[3:0] == flvp_pkg::LEGACY_AVC)
                b0[3] = 1'b1;
            body.push_back(b0);
        end else if (pick < 40) begin
            body.push_back({1'b0, 3'($urandom_range(7)), flvp_pkg::LEGACY_AVC});
            repeat (4) body.push_back(8'($urandom));
        end else if (pick < 88) begin
            if (pick >= 76) begin
                if ($urandom_range(1))
                    fcc = $urandom;
                else
                    ept = 4'($urandom_range(4, 15));
            end
            body.push_back({1'b1, ept, 3'($urandom_range(7))});
            for (int i = 3; i >= 0; i--)
                body.push_back(fcc[8*i +: 8]);
            if (ept == flvp_pkg::EPT_NALU)
                repeat (3) body.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 8)) body.push_back(8'($urandom));
        end
        if (pick < 88) begin
            n = $urandom_range(0, 6);
            repeat (n) body.push_back(8'($urandom));
        end
        if ($urandom_range(9) == 0 && body.size() > 1)
            body = body[0:$urandom_range(body.size() - 2)];
        foreach (body[i])
            send_byte(body[i], i == body.size() - 1, ROW_PREDICT, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        flvp_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (due_results.size() == 0) begin
                $error("unexpected result word kind %0d", out_word.kind);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(out_word.kind));
                check_field("enhanced", 32'(want.enhanced), 32'(out_word.enhanced));
                check_field("frame_type", 32'(want.frame_type), 32'(out_word.frame_type));
                check_field("codec_id", 32'(want.codec_id), 32'(out_word.codec_id));
                check_field("packet_kind", 32'(want.packet_kind), 32'(out_word.packet_kind));
                check_field("time_offset", 32'(want.time_offset), 32'(out_word.time_offset));
                check_field("payload_byte", 32'(want.payload_byte),
                            32'(out_word.payload_byte));
                check_field("fault_code", 32'(want.fault_code), 32'(out_word.fault_code));
                check_field("final_res", 32'(want.final_res), 32'(out_word.final_res));
            end
        end
    end

    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        clear_parser();
        add_row(8'h12, 1'b1, ROW_RESULT, header_word(1'b0, 4'd1, 4'd2, 8'd0, 24'd0, 1'b1));
        add_row(8'h7F, 1'b0, ROW_RESULT, header_word(1'b0, 4'd7, 4'd15, 8'd0, 24'd0, 1'b0));
        add_row(8'h00, 1'b0, ROW_RESULT, payload_word(8'h00, 1'b0));
        add_row(8'hFF, 1'b1, ROW_RESULT, payload_word(8'hFF, 1'b1));
        add_row(8'h27, 1'b0, ROW_SILENT, '0);
        add_row(8'h00, 1'b1, ROW_RESULT, fault_word(flvp_pkg::FAULT_SHORT, 1'b1));
        add_row(8'h17, 1'b0, ROW_PREDICT, '0);
        add_row(8'h01, 1'b0, ROW_PREDICT, '0);
        add_row(8'hFF, 1'b0, ROW_PREDICT, '0);
        add_row(8'hFF, 1'b0, ROW_PREDICT, '0);
        add_row(8'hFE, 1'b1, ROW_PREDICT, '0);
        add_row(8'hFF, 1'b0, ROW_SILENT, '0);
        add_row(8'h61, 1'b0, ROW_SILENT, '0);
        add_row(8'h76, 1'b0, ROW_SILENT, '0);
        add_row(8'h30, 1'b0, ROW_SILENT, '0);
        add_row(8'h31, 1'b0, ROW_RESULT, fault_word(flvp_pkg::FAULT_UNSUP, 1'b0));
        add_row(8'h55, 1'b0, ROW_SILENT, '0);
        add_row(8'h00, 1'b1, ROW_SILENT, '0);
        add_row(8'h98, 1'b0, ROW_PREDICT, '0);
        add_row(8'h76, 1'b0, ROW_PREDICT, '0);
        add_row(8'h70, 1'b0, ROW_PREDICT, '0);
        add_row(8'h30, 1'b0, ROW_PREDICT, '0);
        add_row(8'h39, 1'b1, ROW_PREDICT, '0);
        add_row(8'h80, 1'b1, ROW_RESULT, fault_word(flvp_pkg::FAULT_SHORT, 1'b1));

        send_idle = 30;
        recv_idle = 68;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].data_byte, dir_rows[i].last, dir_rows[i].mode,
                      dir_rows[i].word);
        while (bytes_sent < 233)
            send_random_body();

        send_idle = 68;
        recv_idle = 30;
        while (bytes_sent < 466)
            send_random_body();

        send_idle = 0;
        recv_idle = 0;
        hold_req = 1'b1;
        while (bytes_sent < 700)
            send_random_body();

        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: filelist.f
design/flvp_pkg.sv
design/flvp_core.sv
design/flv_video_tag_parser_top.sv
bench/tb.sv
